// ----- rtl/core/srpb_pkg.sv -----
// Package with the mode, command and control types shared by the recorder modules.
package srpb_pkg;

   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned CMD_W = 3;

   typedef enum logic [1:0] {
      MODE_OFF  = 2'd0,
      MODE_ON   = 2'd1,
      MODE_REC  = 2'd2,
      MODE_PLAY = 2'd3
   } mode_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK   = 3'd0,
      CMD_POWER  = 3'd1,
      CMD_RECORD = 3'd2,
      CMD_STOP   = 3'd3,
      CMD_PLAY   = 3'd4
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     wr_en;
   } ctrl_type;

endpackage

// ----- rtl/core/srpb_if.sv -----
// Valid/ready channel interfaces for the recorder's request and response beats.
interface srpb_req_if import srpb_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [CMD_W-1:0]           command;
   logic                       has_power;
   logic signed [SAMPLE_W-1:0] audio_in_left;
   logic signed [SAMPLE_W-1:0] audio_in_right;

   modport source (output valid, command, has_power, audio_in_left, audio_in_right,
                   input ready);
   modport sink (input valid, command, has_power, audio_in_left, audio_in_right,
                 output ready);
endinterface

interface srpb_rsp_if import srpb_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] audio_out_left;
   logic signed [SAMPLE_W-1:0] audio_out_right;
   logic [1:0]                 mode;
   logic                       record_lamp;
   logic                       play_lamp;
   logic                       power_lamp;

   modport source (output valid, audio_out_left, audio_out_right, mode, record_lamp,
                   play_lamp, power_lamp, input ready);
   modport sink (input valid, audio_out_left, audio_out_right, mode, record_lamp,
                 play_lamp, power_lamp, output ready);
endinterface

// ----- rtl/core/srpb_ctrl.sv -----
// Mode and position sequencer of the recorder.
module srpb_ctrl import srpb_pkg::*; #(
   parameter int unsigned BUFFER_DEPTH = 128
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [CMD_W-1:0]                command,
   input  logic                            has_power,
   output ctrl_type                        ctrl,
   output logic [$clog2(BUFFER_DEPTH)-1:0] pos
);

   localparam int unsigned PW = $clog2(BUFFER_DEPTH);
   localparam logic [PW:0] DEPTH_W = (PW+1)'(BUFFER_DEPTH);

   mode_type      mode_ff, mode_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [PW:0]   pos_inc;
   logic          wrap;
   cmd_type       cmd;

   assign cmd     = cmd_type'(command);
   assign pos_inc = {1'b0, pos_ff} + {{PW{1'b0}}, 1'b1};
   assign wrap    = (pos_inc == DEPTH_W);

   // Next state.
   always_comb begin
      mode_in = mode_ff;
      pos_in  = pos_ff;
      if (accept) begin
         unique case (cmd)
            CMD_TICK: begin
               if (!has_power) begin
                  mode_in = MODE_OFF;
               end else if (mode_ff == MODE_REC || mode_ff == MODE_PLAY) begin
                  if (wrap) begin
                     mode_in = MODE_ON;
                     pos_in  = '0;
                  end else begin
                     pos_in = pos_inc[PW-1:0];
                  end
               end
            end
            CMD_POWER: begin
               if (mode_ff != MODE_OFF) begin
                  mode_in = MODE_OFF;
               end else if (has_power) begin
                  mode_in = MODE_ON;
               end
            end
            CMD_RECORD, CMD_STOP, CMD_PLAY: begin
               if (has_power) begin
                  pos_in = '0;
                  unique case (cmd)
                     CMD_RECORD: mode_in = MODE_REC;
                     CMD_PLAY:   mode_in = MODE_PLAY;
                     default:    mode_in = MODE_ON;
                  endcase
               end else begin
                  mode_in = MODE_OFF;
               end
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   // Outputs: the updated mode and position address this beat's buffer access.
   always_comb begin
      ctrl.mode  = mode_in;
      ctrl.wr_en = accept && (cmd == CMD_TICK) && has_power && (mode_ff == MODE_REC) && !wrap;
      pos        = pos_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_OFF;
         pos_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         pos_ff  <= pos_in;
      end
   end

endmodule

// ----- rtl/core/srpb_lane.sv -----
// One channel lane: sample buffer with registered read and a fill mark for unwritten slots.
module srpb_lane import srpb_pkg::*; #(
   parameter int unsigned BUFFER_DEPTH = 128
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            wr_en,
   input  logic                            rd_en,
   input  logic [$clog2(BUFFER_DEPTH)-1:0] addr,
   input  logic [SAMPLE_W-1:0]             wr_data,
   output logic [SAMPLE_W-1:0]             rd_sample
);

   localparam int unsigned PW = $clog2(BUFFER_DEPTH);

   logic [SAMPLE_W-1:0] mem [BUFFER_DEPTH];
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic                hit_ff;
   logic [PW-1:0]       fill_ff, fill_in;

   // Recording always starts at slot 0 and walks upward, so the written slots are
   // exactly one through the highest address written so far.
   assign fill_in = (wr_en && (addr > fill_ff)) ? addr : fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
         hit_ff     <= (addr != '0) && (addr <= fill_ff);
      end
   end

   assign rd_sample = hit_ff ? rd_data_ff : '0;

endmodule

// ----- rtl/core/stereo_record_playback_buffer_unit.sv -----
// Top level of the stereo record/playback buffer: sequencer, two channel lanes and merge stage.
//
//   channel  | dir | payload                                          | handshake
//   req_bus  | in  | command, has_power, audio_in_left/right          | valid/ready
//   rsp_bus  | out | audio_out_left/right, mode, three lamps          | valid/ready
//
// One beat per cycle sustained while rsp_bus is ready; a result passes through the registered
// buffer read in the read stage, then the merge into the output register.
// Reset clears mode, position and the lanes' fill marks at once; no clearing pass.
// A stalled response holds the output register and the read stage behind it; req_bus
// ready drops only when both are full and rsp_bus is not ready.
module stereo_record_playback_buffer_unit import srpb_pkg::*; #(
   parameter int unsigned BUFFER_DEPTH = 128
) (
   input  logic clock,
   input  logic reset,
   srpb_req_if.sink   req_bus,
   srpb_rsp_if.source rsp_bus
);

   localparam int unsigned PW = $clog2(BUFFER_DEPTH);

   ctrl_type            ctrl;
   logic [PW-1:0]       pos;
   logic                accept;
   logic                s1_move;
   logic [SAMPLE_W-1:0] lane_left, lane_right;

   logic                s1_valid_ff, s1_valid_in;
   mode_type            s1_mode_ff;
   logic                s1_powered_ff;
   logic [SAMPLE_W-1:0] s1_left_ff, s1_right_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] out_left_ff, out_left_in, out_right_ff, out_right_in;
   mode_type            out_mode_ff;
   logic                rec_lamp_ff, rec_lamp_in;
   logic                play_lamp_ff, play_lamp_in;
   logic                pwr_lamp_ff, pwr_lamp_in;

   assign s1_move       = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || s1_move;
   assign accept        = req_bus.valid && req_bus.ready;

   srpb_ctrl #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .command   (req_bus.command),
      .has_power (req_bus.has_power),
      .ctrl      (ctrl),
      .pos       (pos)
   );

   srpb_lane #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_lane_left (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (ctrl.wr_en),
      .rd_en     (accept),
      .addr      (pos),
      .wr_data   (req_bus.audio_in_left),
      .rd_sample (lane_left)
   );

   srpb_lane #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_lane_right (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (ctrl.wr_en),
      .rd_en     (accept),
      .addr      (pos),
      .wr_data   (req_bus.audio_in_right),
      .rd_sample (lane_right)
   );

   // Read stage: hold the beat's context while the lanes fetch the stored samples.
   assign s1_valid_in = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mode_ff    <= ctrl.mode;
         s1_powered_ff <= req_bus.has_power;
         s1_left_ff    <= req_bus.audio_in_left;
         s1_right_ff   <= req_bus.audio_in_right;
      end
   end

   // Merge stage: pick stored or live samples (zero without power) and derive the lamps.
   always_comb begin
      out_left_in  = '0;
      out_right_in = '0;
      if (s1_powered_ff) begin
         if (s1_mode_ff == MODE_PLAY) begin
            out_left_in  = lane_left;
            out_right_in = lane_right;
         end else begin
            out_left_in  = s1_left_ff;
            out_right_in = s1_right_ff;
         end
      end
      rec_lamp_in  = s1_powered_ff && (s1_mode_ff == MODE_REC);
      play_lamp_in = s1_powered_ff && (s1_mode_ff == MODE_PLAY);
      pwr_lamp_in  = s1_powered_ff && (s1_mode_ff != MODE_OFF);
   end

   assign rsp_valid_in = s1_move ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_left_ff  <= out_left_in;
         out_right_ff <= out_right_in;
         out_mode_ff  <= s1_mode_ff;
         rec_lamp_ff  <= rec_lamp_in;
         play_lamp_ff <= play_lamp_in;
         pwr_lamp_ff  <= pwr_lamp_in;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.audio_out_left  = out_left_ff;
   assign rsp_bus.audio_out_right = out_right_ff;
   assign rsp_bus.mode            = out_mode_ff;
   assign rsp_bus.record_lamp     = rec_lamp_ff;
   assign rsp_bus.play_lamp       = play_lamp_ff;
   assign rsp_bus.power_lamp      = pwr_lamp_ff;

`ifndef SYNTHESIS
   // A buffer write only happens on an accepted beat that stays in record mode.
   a_write_in_record: assert property (@(posedge clock) disable iff (reset)
      ctrl.wr_en |-> (accept && ctrl.mode == MODE_REC))
      else $error("buffer write outside record mode");

   // Slot zero is never written; the lanes read it as zero.
   a_no_slot_zero: assert property (@(posedge clock) disable iff (reset)
      ctrl.wr_en |-> (pos != '0))
      else $error("buffer write to slot zero");

   // Backpressure only when both stages are full and the response is stalled.
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> (s1_valid_ff && rsp_valid_ff && !rsp_bus.ready))
      else $error("request stalled with room in the pipeline");

   // Every accepted beat occupies the read stage on the next cycle.
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted beat lost from read stage");
`endif

endmodule
